[hw/rtl/flow_byte_accounting_table_macros.svh]
// assertion macros for the flow byte accounting table checker
`ifndef FLOW_BYTE_ACCOUNTING_TABLE_MACROS_SVH
`define FLOW_BYTE_ACCOUNTING_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FBAT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flow table check failed");

// next-cycle implication, sampled on clk, off during reset
`define FBAT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flow table check failed");

`endif

[hw/rtl/fbat_pkg.sv]
// types and constants shared by the flow byte accounting table
`timescale 1ns / 1ps
`default_nettype none
package fbat_pkg;

    localparam int FLOW_ENTRIES = 64;
    localparam int SLOT_W       = $clog2(FLOW_ENTRIES);
    localparam int COUNT_W      = $clog2(FLOW_ENTRIES + 1);
    localparam int ADDR_W       = 32;
    localparam int PROTO_W      = 8;
    localparam int PORT_W       = 16;
    localparam int LEN_W        = 16;
    localparam int BYTES_W      = 32;
    localparam int IDX_W        = 6;
    localparam int FLOWS_W      = 7;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PROTO_W-1:0] TCP_PROTOCOL_NUM = 8'd6;
    localparam logic [PROTO_W-1:0] UDP_PROTOCOL_NUM = 8'd17;
    localparam logic OP_ACCOUNT = 1'b0;
    localparam logic OP_READOUT = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0]  src_addr;
        logic [ADDR_W-1:0]  dst_addr;
        logic [PROTO_W-1:0] protocol;
        logic [PORT_W-1:0]  source_port;
        logic [PORT_W-1:0]  dest_port;
    } flow_key_t;

    localparam int KEY_W = $bits(flow_key_t);

    typedef enum logic [1:0] {
        ITEM_HIT,
        ITEM_ALLOC,
        ITEM_DROP,
        ITEM_READ
    } item_kind_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [SLOT_W-1:0]  slot;
        logic [IDX_W-1:0]   read_index;
        logic               slot_valid;
        logic [LEN_W-1:0]   packet_length;
        logic [FLOWS_W-1:0] flows;
    } work_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        flow_key_t         key;
    } key_wr_t;

    typedef struct packed {
        logic [IDX_W-1:0]   entry_slot;
        logic               new_flow;
        logic               table_full_drop;
        logic               entry_valid;
        logic [BYTES_W-1:0] byte_total;
        flow_key_t          key;
        logic [FLOWS_W-1:0] flows_in_use;
    } result_t;

    typedef enum logic {
        BK_IDLE,
        BK_CALC
    } back_state_t;

endpackage
`default_nettype wire

[hw/rtl/fbat_if.sv]
// word channels into and out of the flow table
`timescale 1ns / 1ps
`default_nettype none
interface fbat_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] packet_length;
    logic [5:0]  read_index;

    modport source (output valid, operation, src_addr, dst_addr, protocol, source_port,
                    dest_port, packet_length, read_index, input ready);
    modport sink (input valid, operation, src_addr, dst_addr, protocol, source_port,
                  dest_port, packet_length, read_index, output ready);
endinterface

interface fbat_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  entry_slot;
    logic        new_flow;
    logic        table_full_drop;
    logic        entry_valid;
    logic [31:0] byte_total;
    logic [31:0] out_src_addr;
    logic [31:0] out_dst_addr;
    logic [7:0]  out_protocol;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [6:0]  flows_in_use;

    modport source (output valid, entry_slot, new_flow, table_full_drop, entry_valid,
                    byte_total, out_src_addr, out_dst_addr, out_protocol, out_src_port,
                    out_dst_port, flows_in_use, input ready);
    modport sink (input valid, entry_slot, new_flow, table_full_drop, entry_valid,
                  byte_total, out_src_addr, out_dst_addr, out_protocol, out_src_port,
                  out_dst_port, flows_in_use, output ready);
endinterface
`default_nettype wire

[hw/rtl/fbat_ram.sv]
// generic single-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module fbat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/fbat_fifo.sv]
// short queue of classified words between front and back
`timescale 1ns / 1ps
`default_nettype none
module fbat_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_en,
    input  wire fbat_pkg::work_t push_data,
    output logic                full,
    input  wire logic           pop_en,
    output fbat_pkg::work_t     pop_data,
    output logic                empty
);
    import fbat_pkg::*;

    work_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_en ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop_en ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_en && !pop_en)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop_en && !push_en)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/fbat_front.sv]
// front: key lookup across all entries, allocation and occupancy
`timescale 1ns / 1ps
`default_nettype none
module fbat_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    fbat_in_if.sink               pkt,
    input  wire logic             q_full,
    output logic                  push_en,
    output fbat_pkg::work_t       push_data,
    output fbat_pkg::key_wr_t     key_wr
);
    import fbat_pkg::*;

    flow_key_t               key_reg [FLOW_ENTRIES];
    logic [FLOW_ENTRIES-1:0] valid_reg, valid_next;
    logic [COUNT_W-1:0]      used_reg, used_next;
    flow_key_t               key;
    logic                    accept;
    logic                    hit_found, free_found;
    logic [SLOT_W-1:0]       hit_slot, free_slot, rd_slot;
    logic                    rd_valid;
    logic                    do_alloc;

    assign pkt.ready = !q_full;
    assign accept    = pkt.valid && pkt.ready;

    always_comb
    begin
        key.src_addr    = pkt.src_addr;
        key.dst_addr    = pkt.dst_addr;
        key.protocol    = pkt.protocol;
        key.source_port = '0;
        key.dest_port   = '0;
        if (pkt.protocol == TCP_PROTOCOL_NUM || pkt.protocol == UDP_PROTOCOL_NUM)
        begin
            key.source_port = pkt.source_port;
            key.dest_port   = pkt.dest_port;
        end
    end

    // lowest matching entry and lowest free entry
    always_comb
    begin
        hit_found  = 1'b0;
        hit_slot   = '0;
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = FLOW_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_reg[i] == key)
            begin
                hit_found = 1'b1;
                hit_slot  = SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    assign rd_slot  = SLOT_W'(pkt.read_index);
    assign rd_valid = (int'(pkt.read_index) < FLOW_ENTRIES) && valid_reg[rd_slot];
    assign do_alloc = accept && pkt.operation == OP_ACCOUNT && !hit_found && free_found;

    always_comb
    begin
        valid_next = valid_reg;
        used_next  = used_reg;
        if (do_alloc)
        begin
            valid_next[free_slot] = 1'b1;
            used_next             = used_reg + COUNT_W'(1);
        end
    end

    always_comb
    begin
        push_en                 = accept;
        push_data.read_index    = pkt.read_index;
        push_data.packet_length = pkt.packet_length;
        push_data.flows         = FLOWS_W'(used_next);
        push_data.slot_valid    = rd_valid;
        if (pkt.operation == OP_READOUT)
        begin
            push_data.kind = ITEM_READ;
            push_data.slot = rd_slot;
        end
        else if (hit_found)
        begin
            push_data.kind = ITEM_HIT;
            push_data.slot = hit_slot;
        end
        else if (free_found)
        begin
            push_data.kind = ITEM_ALLOC;
            push_data.slot = free_slot;
        end
        else
        begin
            push_data.kind = ITEM_DROP;
            push_data.slot = '0;
        end
        key_wr.en   = do_alloc;
        key_wr.addr = free_slot;
        key_wr.key  = key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            used_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_alloc)
        begin
            key_reg[free_slot] <= key;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/fbat_back.sv]
// back: counter read-modify-write, key readout and result register
`timescale 1ns / 1ps
`default_nettype none
module fbat_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_empty,
    input  wire fbat_pkg::work_t           pop_data,
    output logic                           pop_en,
    output logic [fbat_pkg::SLOT_W-1:0]    key_raddr,
    input  wire fbat_pkg::flow_key_t       key_rdata,
    fbat_out_if.source                     res
);
    import fbat_pkg::*;

    back_state_t         state_reg, state_next;
    work_t               work_reg;
    result_t             res_reg, res_calc;
    logic                res_valid_reg, res_valid_next;
    logic                load;
    logic                cnt_we;
    logic [BYTES_W-1:0]  cnt_wdata, cnt_rdata;
    logic [BYTES_W:0]    sum;

    fbat_ram #(.WIDTH(BYTES_W), .DEPTH(FLOW_ENTRIES)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (work_reg.slot),
        .wdata (cnt_wdata),
        .raddr (pop_data.slot),
        .rdata (cnt_rdata)
    );

    assign key_raddr = pop_data.slot;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop_en)
                begin
                    state_next = BK_CALC;
                end
            end
            BK_CALC: state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop_en = 1'b0;
        load   = 1'b0;
        case (state_reg)
            BK_IDLE: pop_en = !q_empty && (!res_valid_reg || res.ready);
            BK_CALC: load = 1'b1;
            default:
            begin
                pop_en = 1'b0;
                load   = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        sum       = {1'b0, cnt_rdata} + (BYTES_W + 1)'(work_reg.packet_length);
        cnt_we    = 1'b0;
        cnt_wdata = BYTES_W'(work_reg.packet_length);
        res_calc  = '0;
        res_calc.flows_in_use = work_reg.flows;
        case (work_reg.kind)
            ITEM_HIT:
            begin
                cnt_we    = load;
                cnt_wdata = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
                res_calc.entry_slot  = IDX_W'(work_reg.slot);
                res_calc.entry_valid = 1'b1;
                res_calc.byte_total  = cnt_wdata;
                res_calc.key         = key_rdata;
            end
            ITEM_ALLOC:
            begin
                cnt_we = load;
                res_calc.entry_slot  = IDX_W'(work_reg.slot);
                res_calc.new_flow    = 1'b1;
                res_calc.entry_valid = 1'b1;
                res_calc.byte_total  = cnt_wdata;
                res_calc.key         = key_rdata;
            end
            ITEM_DROP: res_calc.table_full_drop = 1'b1;
            ITEM_READ:
            begin
                res_calc.entry_slot  = work_reg.read_index;
                res_calc.entry_valid = work_reg.slot_valid;
                if (work_reg.slot_valid)
                begin
                    res_calc.byte_total = cnt_rdata;
                    res_calc.key        = key_rdata;
                end
            end
            default: res_calc.table_full_drop = 1'b0;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_en)
        begin
            work_reg <= pop_data;
        end
        if (load)
        begin
            res_reg <= res_calc;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.entry_slot      = res_reg.entry_slot;
    assign res.new_flow        = res_reg.new_flow;
    assign res.table_full_drop = res_reg.table_full_drop;
    assign res.entry_valid     = res_reg.entry_valid;
    assign res.byte_total      = res_reg.byte_total;
    assign res.out_src_addr    = res_reg.key.src_addr;
    assign res.out_dst_addr    = res_reg.key.dst_addr;
    assign res.out_protocol    = res_reg.key.protocol;
    assign res.out_src_port    = res_reg.key.source_port;
    assign res.out_dst_port    = res_reg.key.dest_port;
    assign res.flows_in_use    = res_reg.flows_in_use;
endmodule
`default_nettype wire

[hw/rtl/flow_byte_accounting_table.sv]
// top level of the flow byte accounting table
// a word is queued, popped into the back work register while its counter is read, then its result word is registered
// the back takes a new word only after the counter ram read-modify-write of the last one (idle and calc states)
// the front takes a word per cycle into a 2-entry queue while the back is busy, unless the queue is full
// reset: asynchronous active low, clears valid bits, flow count, queue and result valid
// key and counter rams are not cleared; a value read from an unwritten entry is never used
`timescale 1ns / 1ps
`default_nettype none
module flow_byte_accounting_table (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fbat_in_if.sink    pkt,
    fbat_out_if.source res
);
    import fbat_pkg::*;

    logic               q_full, q_empty, push_en, pop_en;
    work_t              push_data, pop_data;
    key_wr_t            key_wr;
    logic [SLOT_W-1:0]  key_raddr;
    flow_key_t          key_rdata;

    fbat_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .q_full    (q_full),
        .push_en   (push_en),
        .push_data (push_data),
        .key_wr    (key_wr)
    );

    fbat_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (push_en),
        .push_data (push_data),
        .full      (q_full),
        .pop_en    (pop_en),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    fbat_ram #(.WIDTH(KEY_W), .DEPTH(FLOW_ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (key_wr.en),
        .waddr (key_wr.addr),
        .wdata (key_wr.key),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    fbat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .pop_data  (pop_data),
        .pop_en    (pop_en),
        .key_raddr (key_raddr),
        .key_rdata (key_rdata),
        .res       (res)
    );
endmodule
`default_nettype wire

[hw/rtl/fbat_checker.sv]
// port-level checks on the flow table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "flow_byte_accounting_table_macros.svh"
module fbat_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        new_flow,
    input wire logic        table_full_drop,
    input wire logic        entry_valid,
    input wire logic [31:0] byte_total,
    input wire logic [6:0]  flows_in_use
);
    `FBAT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(byte_total))
    `FBAT_ASSERT_NOW(a_drop_empty, res_valid && table_full_drop, !new_flow && !entry_valid && byte_total == 32'd0)
    `FBAT_ASSERT_NOW(a_new_valid, res_valid && new_flow, entry_valid && flows_in_use != 7'd0)
    `FBAT_ASSERT_NOW(a_flow_range, res_valid, flows_in_use <= 7'd64)
endmodule

bind flow_byte_accounting_table fbat_checker u_fbat_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .new_flow        (res.new_flow),
    .table_full_drop (res.table_full_drop),
    .entry_valid     (res.entry_valid),
    .byte_total      (res.byte_total),
    .flows_in_use    (res.flows_in_use)
);
`default_nettype wire

[verif/tb_top.sv]
// testbench for the flow byte accounting table: random and directed words, scoreboard check
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import fbat_pkg::*;

    typedef struct {
        logic [5:0]  slot;
        logic        new_flow;
        logic        drop;
        logic        valid;
        logic [31:0] bytes;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [6:0]  flows;
    } flow_report_t;

    class flow_scoreboard;
        logic [31:0] tab_src [FLOW_ENTRIES];
        logic [31:0] tab_dst [FLOW_ENTRIES];
        logic [7:0]  tab_proto [FLOW_ENTRIES];
        logic [15:0] tab_sport [FLOW_ENTRIES];
        logic [15:0] tab_dport [FLOW_ENTRIES];
        logic [31:0] tab_bytes [FLOW_ENTRIES];
        bit          tab_valid [FLOW_ENTRIES];
        int          used;
        flow_report_t pending[$];
        int          errors;

        function void clear();
            for (int i = 0; i < FLOW_ENTRIES; i++)
                tab_valid[i] = 0;
            used = 0;
            errors = 0;
        endfunction

        function void fill_entry(ref flow_report_t r, input int s);
            r.slot  = 6'(s);
            r.valid = 1;
            r.bytes = tab_bytes[s];
            r.src   = tab_src[s];
            r.dst   = tab_dst[s];
            r.proto = tab_proto[s];
            r.sport = tab_sport[s];
            r.dport = tab_dport[s];
        endfunction

        function void note_word(logic op, logic [31:0] src, logic [31:0] dst, logic [7:0] proto,
                                logic [15:0] sport, logic [15:0] dport, logic [15:0] len,
                                logic [5:0] ridx);
            flow_report_t r;
            int hit;
            int free_s;
            logic [32:0] sum;
            r = '{default: '0};
            hit = -1;
            free_s = -1;
            if (op == OP_READOUT) begin
                r.slot = ridx;
                if (tab_valid[ridx])
                    fill_entry(r, ridx);
            end else begin
                if (proto != TCP_PROTOCOL_NUM && proto != UDP_PROTOCOL_NUM) begin
                    sport = '0;
                    dport = '0;
                end
                for (int i = 0; i < FLOW_ENTRIES; i++) begin
                    if (tab_valid[i]) begin
                        if (hit < 0 && tab_src[i] == src && tab_dst[i] == dst
                            && tab_proto[i] == proto && tab_sport[i] == sport
                            && tab_dport[i] == dport)
                            hit = i;
                    end else if (free_s < 0) begin
                        free_s = i;
                    end
                end
                if (hit >= 0) begin
                    sum = {1'b0, tab_bytes[hit]} + 33'(len);
                    tab_bytes[hit] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    fill_entry(r, hit);
                end else if (free_s >= 0) begin
                    tab_src[free_s] = src;
                    tab_dst[free_s] = dst;
                    tab_proto[free_s] = proto;
                    tab_sport[free_s] = sport;
                    tab_dport[free_s] = dport;
                    tab_bytes[free_s] = 32'(len);
                    tab_valid[free_s] = 1;
                    used++;
                    fill_entry(r, free_s);
                    r.new_flow = 1;
                end else begin
                    r.drop = 1;
                end
            end
            r.flows = 7'(used);
            pending.push_back(r);
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s expected %h actual %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_report(flow_report_t a);
            flow_report_t e;
            if (pending.size() == 0) begin
                $error("result word with nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("entry_slot", 32'(e.slot), 32'(a.slot));
            cmp("new_flow", 32'(e.new_flow), 32'(a.new_flow));
            cmp("table_full_drop", 32'(e.drop), 32'(a.drop));
            cmp("entry_valid", 32'(e.valid), 32'(a.valid));
            cmp("byte_total", e.bytes, a.bytes);
            cmp("out_src_addr", e.src, a.src);
            cmp("out_dst_addr", e.dst, a.dst);
            cmp("out_protocol", 32'(e.proto), 32'(a.proto));
            cmp("out_src_port", 32'(e.sport), 32'(a.sport));
            cmp("out_dst_port", 32'(e.dport), 32'(a.dport));
            cmp("flows_in_use", 32'(e.flows), 32'(a.flows));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    fbat_in_if  pkt ();
    fbat_out_if res ();
    flow_scoreboard sb;
    int idle_cycles;
    int burst_left;
    bit stall_free;
    int rx_phase;

    flow_byte_accounting_table dut (.clk(clk), .rst_n(rst_n), .pkt(pkt.sink), .res(res.source));

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver stall pattern and result check
    always @(posedge clk)
    begin
        flow_report_t a;
        if (rst_n && res.valid && res.ready) begin
            a.slot = res.entry_slot;
            a.new_flow = res.new_flow;
            a.drop = res.table_full_drop;
            a.valid = res.entry_valid;
            a.bytes = res.byte_total;
            a.src = res.out_src_addr;
            a.dst = res.out_dst_addr;
            a.proto = res.out_protocol;
            a.sport = res.out_src_port;
            a.dport = res.out_dst_port;
            a.flows = res.flows_in_use;
            sb.check_report(a);
        end
    end

    always @(negedge clk)
    begin
        rx_phase <= rx_phase + 1;
        if (stall_free)
            res.ready <= 1'b1;
        else if (rx_phase[6])
            res.ready <= (rx_phase % 3) != 0;
        else
            res.ready <= $urandom_range(0, 3) != 0;
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((pkt.valid && pkt.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("flow_byte_accounting_table verification failed");
            $finish;
        end
    end

    task automatic send_word(logic op, logic [31:0] src, logic [31:0] dst, logic [7:0] proto,
                             logic [15:0] sport, logic [15:0] dport, logic [15:0] len,
                             logic [5:0] ridx);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                pkt.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        pkt.valid <= 1'b1;
        pkt.operation <= op;
        pkt.src_addr <= src;
        pkt.dst_addr <= dst;
        pkt.protocol <= proto;
        pkt.source_port <= sport;
        pkt.dest_port <= dport;
        pkt.packet_length <= len;
        pkt.read_index <= ridx;
        @(posedge clk);
        while (!pkt.ready)
            @(posedge clk);
        sb.note_word(op, src, dst, proto, sport, dport, len, ridx);
        @(negedge clk);
    endtask

    task automatic random_word(logic op);
        send_word(op, $urandom, $urandom, 8'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 6'($urandom));
    endtask

    task automatic drain();
        pkt.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_pkt(int pool);
        logic [7:0] pr;
        int k;
        k = $urandom_range(0, pool);
        case ($urandom_range(0, 3))
            0: pr = TCP_PROTOCOL_NUM;
            1: pr = UDP_PROTOCOL_NUM;
            default: pr = 8'($urandom);
        endcase
        if ($urandom_range(0, 3) != 0)
            send_word(OP_ACCOUNT, 32'h0A00_0000 + 32'(k), 32'hC0A8_0000 + 32'(k[2:0]), pr,
                      16'(k * 7), k[0] ? 16'hFFFF : 16'h0050, 16'($urandom), 6'($urandom));
        else
            random_word(OP_ACCOUNT);
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        burst_left = 0;
        stall_free = 0;
        rx_phase = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        pkt.valid = 1'b0;
        pkt.operation = OP_ACCOUNT;
        pkt.src_addr = '0;
        pkt.dst_addr = '0;
        pkt.protocol = '0;
        pkt.source_port = '0;
        pkt.dest_port = '0;
        pkt.packet_length = '0;
        pkt.read_index = '0;
        res.ready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty readouts, extremes, port masking, hits, large counts
        send_word(OP_READOUT, '0, '0, '0, '0, '0, '0, 6'd0);
        send_word(OP_READOUT, '1, '1, '1, '1, '1, '1, 6'd63);
        send_word(OP_ACCOUNT, '0, '0, TCP_PROTOCOL_NUM, '0, '0, '0, '0);
        send_word(OP_ACCOUNT, '1, '1, UDP_PROTOCOL_NUM, '1, '1, '1, '1);
        send_word(OP_ACCOUNT, '1, '1, 8'hFF, '1, '1, '1, '0);
        send_word(OP_ACCOUNT, '1, '1, 8'hFF, 16'h1234, 16'h0, 16'h10, '0);
        send_word(OP_ACCOUNT, 32'h1, 32'h2, TCP_PROTOCOL_NUM, 16'h1, 16'h2, '1, '0);
        for (int i = 0; i < 3; i++)
            send_word(OP_ACCOUNT, '1, '1, UDP_PROTOCOL_NUM, '1, '1, '1, '0);
        send_word(OP_READOUT, '0, '0, '0, '0, '0, '0, 6'd1);
        send_word(OP_READOUT, '0, '0, '0, '0, '0, '0, 6'd2);
        // pause until everything has come back
        drain();
        stall_free = 1;
        // heavy traffic on one flow
        for (int i = 0; i < 8; i++)
            send_word(OP_ACCOUNT, 32'hDEAD_0000, 32'hBEEF, 8'd1, '0, '0, 16'hFFFF, '0);
        stall_free = 0;

        // random: mixed packets and readouts over a small flow pool, then fill the table, then mix again
        for (int n = 0; n < 200; n++) begin
            if ($urandom_range(0, 4) == 0)
                random_word(OP_READOUT);
            else
                random_pkt(20);
        end
        drain();
        for (int n = 0; n < 80; n++)
            random_word(OP_ACCOUNT);
        for (int n = 0; n < 170; n++) begin
            if ($urandom_range(0, 2) == 0)
                random_word(OP_READOUT);
            else
                random_pkt(20);
        end

        drain();
        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("flow_byte_accounting_table verification clean");
        else
            $display("flow_byte_accounting_table verification failed");
        $finish;
    end
endmodule
`default_nettype wire

[flow_byte_accounting_table.f]
+incdir+hw/rtl
hw/rtl/fbat_pkg.sv
hw/rtl/fbat_if.sv
hw/rtl/fbat_ram.sv
hw/rtl/fbat_fifo.sv
hw/rtl/fbat_front.sv
hw/rtl/fbat_back.sv
hw/rtl/flow_byte_accounting_table.sv
hw/rtl/fbat_checker.sv
verif/tb_top.sv
